// ===== src/tick_ordered_input_reorder_buffer_macros.svh =====
// Assertion macros used by the checker in src/toirb_checker.sv.
`ifndef TICK_ORDERED_INPUT_REORDER_BUFFER_MACROS_SVH
`define TICK_ORDERED_INPUT_REORDER_BUFFER_MACROS_SVH

`define TOIRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define TOIRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/toirb_pkg.sv =====
package toirb_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int DEPTH_DEF = 8;
  localparam int TICK_W = 32;
  localparam int AXIS_W = 16;
  localparam int BTN_W = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_W = 8;
  localparam int IN_DATA_W = 88;
  localparam int OP_W = 86;
  localparam int OUT_DATA_W = 88;
  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sd16384;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = -16'sd16384;

  localparam logic [1:0] KIND_ENQ = 2'd0;
  localparam logic [1:0] KIND_PROC = 2'd1;
  localparam logic [1:0] KIND_ADV = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEDUPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_OLD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_EARLY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE = 3'd4;

  localparam logic CFG_PAST = 1'b0;
  localparam logic CFG_FUTURE = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [2*AXIS_W-1:0] axes;
    logic [BTN_W-1:0] btn;
  } entry_t;

  typedef struct packed {
    logic load;
    logic rd_start;
    logic cmp;
    logic fill_write;
    logic finish;
    logic advance;
  } ctl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic too_old;
    logic too_early;
    logic rd_done;
    logic cmp_done;
  } sts_t;

  function automatic logic [AXIS_W-1:0] clamp_axis(input logic [AXIS_W-1:0] v);
    logic signed [AXIS_W-1:0] a;
    a = $signed(v);
    if (a < AXIS_MIN) return AXIS_MIN;
    if (a > AXIS_MAX) return AXIS_MAX;
    return v;
  endfunction

endpackage

// ===== src/toirb_ctrl.sv =====
module toirb_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_fire,
  input  toirb_pkg::sts_t sts,
  output toirb_pkg::ctl_t ctl,
  output logic busy,
  output logic out_valid
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_READ, S_CMP, S_WRITE, S_OUT} state_t;
  state_t state;

  always_comb begin
    ctl = '0;
    ctl.load = in_fire;
    ctl.rd_start = (state == S_CHECK) && (sts.kind == toirb_pkg::KIND_ENQ ||
                   sts.kind == toirb_pkg::KIND_PROC) &&
                   !(sts.kind == toirb_pkg::KIND_ENQ && (sts.too_old || sts.too_early));
    ctl.cmp = (state == S_CMP);
    ctl.fill_write = (state == S_WRITE);
    ctl.advance = (state == S_CHECK) && (sts.kind == toirb_pkg::KIND_ADV);
    ctl.finish = (state == S_CHECK) && !ctl.rd_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_CHECK;
            busy <= 1'b1;
          end
        end
        S_CHECK: state <= ctl.rd_start ? S_READ : S_WRITE;
        S_READ: if (sts.rd_done) state <= S_CMP;
        S_CMP: if (sts.cmp_done) state <= S_WRITE;
        S_WRITE: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: begin
          if (out_fire) begin
            state <= S_IDLE;
            out_valid <= 1'b0;
            busy <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/toirb_dp.sv =====
module toirb_dp #(
  parameter int SLOTS = toirb_pkg::SLOTS_DEF,
  parameter int DEPTH = toirb_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  toirb_pkg::ctl_t ctl,
  output toirb_pkg::sts_t sts,
  input  logic [toirb_pkg::OP_W-1:0] in_data,
  input  logic [toirb_pkg::CFG_W-1:0] past_window,
  input  logic [toirb_pkg::CFG_W-1:0] future_window,
  output logic [toirb_pkg::OUT_DATA_W-1:0] out_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 2);
  localparam int MEM = SLOTS * DEPTH;
  localparam int AW = (MEM > 1) ? $clog2(MEM) : 1;
  localparam int TW = toirb_pkg::TICK_W;

  toirb_pkg::entry_t mem [MEM];
  toirb_pkg::entry_t rd_q;
  toirb_pkg::entry_t buf_e [DEPTH+1];
  logic [CW-1:0] slot_fill [SLOTS];
  logic [2*toirb_pkg::AXIS_W+toirb_pkg::BTN_W-1:0] intent [SLOTS];
  logic [TW-1:0] taken [SLOTS];
  logic [TW-1:0] now_tick;

  logic [1:0] kind;
  logic [SW-1:0] slot;
  toirb_pkg::entry_t cmd;
  logic [CW-1:0] n, rd_idx, wr_idx, src, cnt_n;
  logic rd_busy, rd_pend;
  logic [toirb_pkg::STATUS_W-1:0] status;
  logic [2:0] phase;
  logic [CW-1:0] pos, d;
  logic found;
  logic [TW:0] now_ext, fut_lim;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  toirb_pkg::entry_t wr_e;
  logic [SW-1:0] in_slot;

  localparam logic [2:0] PH_POS = 3'd0, PH_INS = 3'd1, PH_STALE = 3'd2,
                         PH_TRIM = 3'd3, PH_WB = 3'd4;

  function automatic logic [SW-1:0] slot_of(input logic [3:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++)
      if (v == 4'(i)) r = SW'(i % SLOTS);
    return r;
  endfunction

  assign now_ext = {1'b0, now_tick};
  assign fut_lim = now_ext + {{(TW+1-toirb_pkg::CFG_W){1'b0}}, future_window};
  assign in_slot = slot_of(in_data[5:2]);

  function automatic logic stale(input logic [TW-1:0] t, input logic [TW:0] nw,
                                 input logic [toirb_pkg::CFG_W-1:0] pw,
                                 input logic incl);
    logic [TW:0] s;
    s = {1'b0, t} + {{(TW+1-toirb_pkg::CFG_W){1'b0}}, pw};
    return incl ? (s <= nw) : (s < nw);
  endfunction

  assign sts.kind = kind;
  assign sts.too_old = stale(cmd.tick, now_ext, past_window, 1'b0);
  assign sts.too_early = {1'b0, cmd.tick} > fut_lim;
  assign sts.rd_done = !rd_busy && !rd_pend;
  assign sts.cmp_done = (phase == PH_WB) && (wr_idx + d >= n);

  assign rd_addr = AW'(slot) * AW'(DEPTH) + AW'(rd_idx);
  assign wr_addr = AW'(slot) * AW'(DEPTH) + AW'(wr_idx);
  assign wr_en = ctl.cmp && (phase == PH_WB) && (wr_idx + d < n);
  assign wr_e = buf_e[DW'(0) + (wr_idx + d)];

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_tick <= '0;
      rd_busy <= 1'b0;
      rd_pend <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_fill[i] <= '0;
        intent[i] <= '0;
        taken[i] <= '0;
      end
    end else begin
      if (ctl.load) begin
        kind <= in_data[1:0];
        slot <= in_slot;
        cmd.tick <= in_data[37:6];
        cmd.axes <= {toirb_pkg::clamp_axis(in_data[69:54]),
                     toirb_pkg::clamp_axis(in_data[53:38])};
        cmd.btn <= in_data[85:70];
        status <= toirb_pkg::ST_NONE;
      end
      if (ctl.advance) now_tick <= now_tick + 1'b1;
      if (ctl.finish && kind == toirb_pkg::KIND_ENQ)
        status <= sts.too_old ? toirb_pkg::ST_TOO_OLD : toirb_pkg::ST_TOO_EARLY;
      if (ctl.rd_start) begin
        n <= (slot_fill[slot] > CW'(DEPTH)) ? CW'(DEPTH) : slot_fill[slot];
        cnt_n <= (slot_fill[slot] > CW'(DEPTH)) ? CW'(DEPTH) : slot_fill[slot];
        rd_idx <= '0;
        src <= '0;
        rd_busy <= 1'b1;
        rd_pend <= 1'b0;
        phase <= PH_POS;
        pos <= '0;
        d <= '0;
        wr_idx <= '0;
        found <= 1'b0;
      end else if (rd_busy || rd_pend) begin
        rd_pend <= rd_busy && (rd_idx < cnt_n);
        if (rd_pend) begin
          buf_e[DW'(0) + src] <= rd_q;
          src <= src + 1'b1;
        end
        if (rd_busy) begin
          if (rd_idx < cnt_n) rd_idx <= rd_idx + 1'b1;
          else rd_busy <= 1'b0;
        end
      end
      if (ctl.cmp) begin
        unique case (phase)
          PH_POS: begin
            if (kind == toirb_pkg::KIND_PROC) begin
              if (d < n && stale(buf_e[d].tick, now_ext, past_window, 1'b1))
                d <= d + 1'b1;
              else phase <= PH_TRIM;
            end else if (pos < n && buf_e[pos].tick < cmd.tick) begin
              pos <= pos + 1'b1;
            end else begin
              found <= pos < n && buf_e[pos].tick == cmd.tick;
              src <= n;
              phase <= PH_INS;
            end
          end
          PH_INS: begin
            if (found) begin
              buf_e[pos] <= cmd;
              status <= toirb_pkg::ST_DEDUPED;
              phase <= PH_STALE;
            end else if (src > pos) begin
              buf_e[src] <= buf_e[src-1'b1];
              src <= src - 1'b1;
            end else begin
              buf_e[pos] <= cmd;
              n <= n + 1'b1;
              status <= toirb_pkg::ST_ACCEPTED;
              phase <= PH_STALE;
            end
          end
          PH_STALE: begin
            if (d < n && stale(buf_e[d].tick, now_ext, past_window, 1'b0))
              d <= d + 1'b1;
            else if (n - d > CW'(DEPTH)) d <= d + 1'b1;
            else phase <= PH_WB;
          end
          PH_TRIM: begin
            if (d < n && buf_e[d].tick <= now_tick) begin
              intent[slot] <= {buf_e[d].btn, buf_e[d].axes};
              taken[slot] <= buf_e[d].tick;
              d <= d + 1'b1;
            end else phase <= PH_WB;
          end
          PH_WB: if (wr_idx + d < n) wr_idx <= wr_idx + 1'b1;
          default: phase <= PH_WB;
        endcase
      end
      if (ctl.fill_write && (kind == toirb_pkg::KIND_ENQ || kind == toirb_pkg::KIND_PROC)
          && phase == PH_WB)
        slot_fill[slot] <= n - d;
      if (ctl.load) phase <= PH_POS;
    end
  end

  assign out_data = {1'b0, 4'(slot_fill[slot]), taken[slot], intent[slot], status};

endmodule

// ===== src/tick_ordered_input_reorder_buffer.sv =====
// Tick-ordered input reorder buffer.
// s_axis carries one operation per transfer: kind 0 enqueues a command into
// the addressed slot, kind 1 processes the slot (drops stale entries, takes
// every due entry as the slot's intent), kind 2 advances the current tick.
// m_axis returns exactly one result per operation: status and the slot's
// intent, last taken tick and fill after the operation.
// cfg_we/cfg_index/cfg_data set past_window (0) and future_window (1).
// One operation at a time. Advance, the unused kind and rejected enqueues pass
// from the input transfer through the check and write states to the result.
// Enqueue and process read the slot's entries from the entry memory, walk them
// one entry a cycle for search, shift, pruning and pop, then write back one
// entry a cycle. The next operation is taken the cycle after the result
// transfer. The one-entry-a-cycle walk and write-back set the rate.
// Reset empties every slot, clears intents and the current tick, and sets
// both windows to 10. When m_axis_tready is low the result holds and no new
// operation is taken.
module tick_ordered_input_reorder_buffer #(
  parameter int SLOTS = toirb_pkg::SLOTS_DEF,
  parameter int DEPTH = toirb_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // slot[3:0], cmd_tick[35:4], axis_x[51:36], axis_y[67:52], button_bits[83:68]
  input  logic [toirb_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // kind
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // status[2:0], intent_x[18:3], intent_y[34:19], intent_buttons[50:35],
  // taken_tick[82:51], fill[86:83]
  output logic [toirb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [toirb_pkg::CFG_W-1:0] cfg_data
);

  logic [toirb_pkg::CFG_W-1:0] past_window, future_window;
  toirb_pkg::ctl_t ctl;
  toirb_pkg::sts_t sts;
  logic busy, in_fire;
  logic [toirb_pkg::OP_W-1:0] in_word;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_word = {s_axis_tdata[toirb_pkg::OP_W-3:0], s_axis_tuser};

  always_ff @(posedge clk) begin
    if (rst) begin
      past_window <= 8'd10;
      future_window <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        toirb_pkg::CFG_PAST: past_window <= cfg_data;
        toirb_pkg::CFG_FUTURE: future_window <= cfg_data;
        default: ;
      endcase
    end
  end

  toirb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_fire(m_axis_tvalid && m_axis_tready),
    .sts(sts), .ctl(ctl), .busy(busy), .out_valid(m_axis_tvalid)
  );

  toirb_dp #(.SLOTS(SLOTS), .DEPTH(DEPTH)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts), .in_data(in_word),
    .past_window(past_window), .future_window(future_window),
    .out_data(m_axis_tdata)
  );

endmodule

// ===== src/toirb_checker.sv =====
`include "tick_ordered_input_reorder_buffer_macros.svh"
module toirb_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [toirb_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  `TOIRB_ASSERT_IMPL(a_one_at_a_time, clk, rst, m_axis_tvalid, !s_axis_tready)
  `TOIRB_ASSERT_NEXT(a_no_result_right_after_take, clk, rst,
    s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
  `TOIRB_ASSERT_IMPL(a_status_range, clk, rst, m_axis_tvalid,
    m_axis_tdata[2:0] <= toirb_pkg::ST_NONE)
  `TOIRB_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind tick_ordered_input_reorder_buffer toirb_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== sim/tick_ordered_input_reorder_buffer_checker.sv =====
`timescale 1ns / 1ps

module tick_ordered_input_reorder_buffer_checker (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [toirb_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [1:0] s_axis_tuser,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [toirb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [toirb_pkg::CFG_W-1:0] cfg_data,
  output int errors,
  output int pending
);

  localparam int NS = toirb_pkg::SLOTS_DEF;
  localparam int ND = toirb_pkg::DEPTH_DEF;
  localparam int QD = 16;

  typedef struct packed {
    logic [toirb_pkg::STATUS_W-1:0] status;
    logic [toirb_pkg::AXIS_W-1:0] ix;
    logic [toirb_pkg::AXIS_W-1:0] iy;
    logic [toirb_pkg::BTN_W-1:0] ib;
    logic [toirb_pkg::TICK_W-1:0] last;
    logic [3:0] fill;
  } slot_report_t;

  logic [toirb_pkg::TICK_W-1:0] now_tick;
  logic [toirb_pkg::CFG_W-1:0] past_win;
  logic [toirb_pkg::CFG_W-1:0] future_win;
  logic [toirb_pkg::TICK_W-1:0] buf_tick [NS][ND];
  logic [2*toirb_pkg::AXIS_W-1:0] buf_axes [NS][ND];
  logic [toirb_pkg::BTN_W-1:0] buf_btn [NS][ND];
  int buf_fill [NS];
  logic [2*toirb_pkg::AXIS_W-1:0] intent_axes [NS];
  logic [toirb_pkg::BTN_W-1:0] intent_btn [NS];
  logic [toirb_pkg::TICK_W-1:0] taken [NS];
  slot_report_t reports_due [QD];
  int wr_cnt = 0;
  int rd_cnt = 0;

  assign pending = wr_cnt - rd_cnt;

  function automatic logic [toirb_pkg::AXIS_W-1:0] limit_axis(
      logic [toirb_pkg::AXIS_W-1:0] v);
    if ($signed(v) < toirb_pkg::AXIS_MIN) return toirb_pkg::AXIS_MIN;
    if ($signed(v) > toirb_pkg::AXIS_MAX) return toirb_pkg::AXIS_MAX;
    return v;
  endfunction

  function automatic logic [toirb_pkg::STATUS_W-1:0] enqueue_cmd(int s,
      logic [toirb_pkg::TICK_W-1:0] tk, logic [2*toirb_pkg::AXIS_W-1:0] ax,
      logic [toirb_pkg::BTN_W-1:0] bt);
    logic [toirb_pkg::TICK_W-1:0] t [ND+1];
    logic [2*toirb_pkg::AXIS_W-1:0] a [ND+1];
    logic [toirb_pkg::BTN_W-1:0] b [ND+1];
    int n, pos, d;
    logic [toirb_pkg::STATUS_W-1:0] st;
    if ({1'b0, tk} + past_win < {1'b0, now_tick}) return toirb_pkg::ST_TOO_OLD;
    if ({1'b0, tk} > {1'b0, now_tick} + future_win) return toirb_pkg::ST_TOO_EARLY;
    n = buf_fill[s];
    pos = 0;
    d = 0;
    st = toirb_pkg::ST_ACCEPTED;
    for (int i = 0; i < n; i++) begin
      t[i] = buf_tick[s][i];
      a[i] = buf_axes[s][i];
      b[i] = buf_btn[s][i];
    end
    while (pos < n && t[pos] < tk) pos++;
    if (pos < n && t[pos] == tk) begin
      st = toirb_pkg::ST_DEDUPED;
    end else begin
      for (int i = n; i > pos; i--) begin
        t[i] = t[i-1];
        a[i] = a[i-1];
        b[i] = b[i-1];
      end
      n++;
    end
    t[pos] = tk;
    a[pos] = ax;
    b[pos] = bt;
    while (d < n && {1'b0, t[d]} + past_win < {1'b0, now_tick}) d++;
    while (n - d > ND) d++;
    for (int i = d; i < n; i++) begin
      buf_tick[s][i-d] = t[i];
      buf_axes[s][i-d] = a[i];
      buf_btn[s][i-d] = b[i];
    end
    buf_fill[s] = n - d;
    return st;
  endfunction

  function automatic void process_slot(int s);
    int n, d;
    n = buf_fill[s];
    d = 0;
    while (d < n && {1'b0, buf_tick[s][d]} + past_win <= {1'b0, now_tick}) d++;
    while (d < n && buf_tick[s][d] <= now_tick) begin
      intent_axes[s] = buf_axes[s][d];
      intent_btn[s] = buf_btn[s][d];
      taken[s] = buf_tick[s][d];
      d++;
    end
    for (int i = d; i < n; i++) begin
      buf_tick[s][i-d] = buf_tick[s][i];
      buf_axes[s][i-d] = buf_axes[s][i];
      buf_btn[s][i-d] = buf_btn[s][i];
    end
    buf_fill[s] = n - d;
  endfunction

  function automatic slot_report_t predict_transfer(logic [1:0] k,
      logic [toirb_pkg::IN_DATA_W-1:0] d);
    slot_report_t r;
    int s;
    s = int'(d[3:0]) % NS;
    r.status = toirb_pkg::ST_NONE;
    if (k == toirb_pkg::KIND_ENQ)
      r.status = enqueue_cmd(s, d[35:4], {limit_axis(d[67:52]), limit_axis(d[51:36])},
                             d[83:68]);
    else if (k == toirb_pkg::KIND_PROC)
      process_slot(s);
    else if (k == toirb_pkg::KIND_ADV)
      now_tick = now_tick + 1'b1;
    r.ix = intent_axes[s][15:0];
    r.iy = intent_axes[s][31:16];
    r.ib = intent_btn[s];
    r.last = taken[s];
    r.fill = 4'(buf_fill[s]);
    return r;
  endfunction

  always @(posedge clk) begin
    slot_report_t want, got;
    if (rst) begin
      now_tick = '0;
      past_win = 8'd10;
      future_win = 8'd10;
      for (int s = 0; s < NS; s++) begin
        buf_fill[s] = 0;
        intent_axes[s] = '0;
        intent_btn[s] = '0;
        taken[s] = '0;
      end
      wr_cnt = 0;
      rd_cnt = 0;
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == toirb_pkg::CFG_PAST) past_win = cfg_data;
        else future_win = cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[2:0];
        got.ix = m_axis_tdata[18:3];
        got.iy = m_axis_tdata[34:19];
        got.ib = m_axis_tdata[50:35];
        got.last = m_axis_tdata[82:51];
        got.fill = m_axis_tdata[86:83];
        if (wr_cnt == rd_cnt) begin
          $display("%0t: expected no result got %h", $time, got);
          errors++;
        end else begin
          want = reports_due[rd_cnt % QD];
          rd_cnt++;
          if (got.status != want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.ix != want.ix) begin
            $display("%0t: intent_x exp %h got %h", $time, want.ix, got.ix);
            errors++;
          end
          if (got.iy != want.iy) begin
            $display("%0t: intent_y exp %h got %h", $time, want.iy, got.iy);
            errors++;
          end
          if (got.ib != want.ib) begin
            $display("%0t: intent_buttons exp %h got %h", $time, want.ib, got.ib);
            errors++;
          end
          if (got.last != want.last) begin
            $display("%0t: taken_tick exp %h got %h", $time, want.last, got.last);
            errors++;
          end
          if (got.fill != want.fill) begin
            $display("%0t: fill exp %0d got %0d", $time, want.fill, got.fill);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (wr_cnt - rd_cnt >= QD) begin
          $display("%0t: outstanding exp below %0d got %0d", $time, QD, wr_cnt - rd_cnt);
          errors++;
        end
        reports_due[wr_cnt % QD] = predict_transfer(s_axis_tuser, s_axis_tdata);
        wr_cnt++;
      end
    end
  end

endmodule

// ===== sim/tb_tick_ordered_input_reorder_buffer.sv =====
`timescale 1ns / 1ps

module tb_tick_ordered_input_reorder_buffer;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [toirb_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = toirb_pkg::KIND_ADV;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [toirb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = toirb_pkg::CFG_PAST;
  logic [toirb_pkg::CFG_W-1:0] cfg_data = '0;
  int errors;
  int pending;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic [toirb_pkg::TICK_W-1:0] cur_tick = '0;
  int cur_past = 10;
  int cur_future = 10;

  tick_ordered_input_reorder_buffer i_dut (.*);

  tick_ordered_input_reorder_buffer_checker i_checker (.*);

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[tick_ordered_input_reorder_buffer] ERROR");
      $finish;
    end
  end

  // receiver: ready always, random, or long stalls, switching now and then
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send(logic [1:0] k, logic [3:0] s, logic [31:0] tk,
      logic [15:0] x, logic [15:0] y, logic [15:0] b);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= {4'b0, b, y, x, tk, s};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (k == toirb_pkg::KIND_ADV) cur_tick = cur_tick + 1'b1;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_windows(int pw, int fw);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= toirb_pkg::CFG_PAST;
    cfg_data <= 8'(pw);
    @(posedge clk);
    cfg_index <= toirb_pkg::CFG_FUTURE;
    cfg_data <= 8'(fw);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_past = pw;
    cur_future = fw;
  endtask

  task automatic random_item();
    int r;
    logic [3:0] s;
    logic [31:0] tk;
    r = $urandom_range(0, 99);
    s = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
    tk = cur_tick + $urandom_range(0, cur_past + cur_future + 6) - cur_past - 3;
    if ($urandom_range(0, 9) == 0) tk = $urandom;
    if (r < 55)
      send(toirb_pkg::KIND_ENQ, s, tk, 16'($urandom), 16'($urandom), 16'($urandom));
    else if (r < 78)
      send(toirb_pkg::KIND_PROC, s, 32'($urandom), '0, '0, '0);
    else if (r < 97)
      send(toirb_pkg::KIND_ADV, s, 32'($urandom), 16'($urandom), '0, '0);
    else
      send(toirb_pkg::KIND_NONE, s, 32'($urandom), '0, '0, 16'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, dedupe, overflow, staleness, unused kind
    send(toirb_pkg::KIND_ENQ, 4'd0, 32'd0, 16'h8000, 16'h7FFF, 16'hFFFF);
    send(toirb_pkg::KIND_ENQ, 4'd0, 32'd0, 16'hC000, 16'h4000, 16'h0000);
    send(toirb_pkg::KIND_ENQ, 4'd15, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000);
    send(toirb_pkg::KIND_ENQ, 4'd15, 32'd10, 16'h4001, 16'hBFFF, 16'hA5A5);
    send(toirb_pkg::KIND_ENQ, 4'd15, 32'd11, 16'h0001, 16'hFFFF, 16'h5A5A);
    for (int i = 9; i >= 1; i--)
      send(toirb_pkg::KIND_ENQ, 4'd1, 32'(i), 16'(i), 16'(-i), 16'(i));
    send(toirb_pkg::KIND_PROC, 4'd0, '0, '0, '0, '0);
    send(toirb_pkg::KIND_PROC, 4'd1, '0, '0, '0, '0);
    repeat (5) send(toirb_pkg::KIND_ADV, 4'd1, '0, '0, '0, '0);
    send(toirb_pkg::KIND_PROC, 4'd1, '0, '0, '0, '0);
    send(toirb_pkg::KIND_NONE, 4'd1, '0, '0, '0, '0);
    repeat (12) send(toirb_pkg::KIND_ADV, 4'd2, '0, '0, '0, '0);
    send(toirb_pkg::KIND_ENQ, 4'd2, 32'd0, 16'h1234, 16'h4321, 16'h00FF);
    send(toirb_pkg::KIND_PROC, 4'd15, '0, '0, '0, '0);
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_windows(0, 0);
        2: set_windows(255, 255);
        3: set_windows(3, 20);
        4: set_windows(20, 3);
        5: set_windows($urandom_range(0, 255), $urandom_range(0, 255));
        default: ;
      endcase
      for (int i = 0; i < 105; i++) begin
        random_item();
        if (i == 50 && ph == 2) drain();
      end
    end
    drain();
    if (errors == 0)
      $display("[tick_ordered_input_reorder_buffer] OK");
    else
      $display("[tick_ordered_input_reorder_buffer] ERROR");
    $finish;
  end

endmodule

// ===== tick_ordered_input_reorder_buffer.f =====
+incdir+src
src/toirb_pkg.sv
src/toirb_ctrl.sv
src/toirb_dp.sv
src/tick_ordered_input_reorder_buffer.sv
src/toirb_checker.sv
sim/tick_ordered_input_reorder_buffer_checker.sv
sim/tb_tick_ordered_input_reorder_buffer.sv
